@@ rtl/core/prefix_trie_counter_top_assert.svh @@
// Assertion macros shared by the prefix trie counter RTL.
`ifndef PREFIX_TRIE_COUNTER_TOP_ASSERT_SVH
`define PREFIX_TRIE_COUNTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ptc check failed");
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptc check failed");
`else
`define PTC_ASSERT(lbl, clk, rst_n, prop)
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ptc_pkg.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter package
// Shared constants, operation and error codes, and saturating count helpers.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;
    localparam int DEF_NODES    = 4096;
    localparam int DEF_ALPHABET = 26;
    localparam int DEF_MAX_LEN  = 64;
    localparam int CNT_W        = 16;
    localparam int FUNC_W       = 3;
    localparam int LETTER_W     = 5;
    localparam int ERR_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_DELETE = 3'd1,
        FN_SEARCH = 3'd2,
        FN_PREFIX = 3'd3,
        FN_CLEAR  = 3'd4
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ER_NONE = 2'd0,
        ER_FULL = 2'd1,
        ER_LONG = 2'd2
    } t_err;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/ptc_if.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter channels
// Valid/ready channels for letter beats in and result beats out.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface ptc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptc_pkg::FUNC_W-1:0]    func;
    logic [ptc_pkg::LETTER_W-1:0]  letter;
    logic                          last;
    modport source (output valid, func, letter, last, input ready);
    modport sink (input valid, func, letter, last, output ready);
endinterface

interface ptc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptc_pkg::CNT_W-1:0]     count;
    logic                          done_res;
    logic [ptc_pkg::ERR_W-1:0]     error;
    modport source (output valid, count, done_res, error, input ready);
    modport sink (input valid, count, done_res, error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ptc_node_mem.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter node memory
// One row per node: all child links, the pass count and the end count.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptc_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 344
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ptc_path_mem.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter path store
// Parent node and letter of each step of a word being deleted.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptc_path_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/prefix_trie_counter_top.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter
// Letter-serial trie with pass and end counts kept in a node row memory.
// -----------------------------------------------------------------------------
// Usage: words enter on i_in one letter per beat with func, letter and last;
// the operation of a word's first beat holds for the whole word. Every
// accepted beat yields exactly one result beat on o_out (count, done_res,
// error). Clear (func 4) zeroes every used node and answers with done_res.
// Sequencing: all node state lives in one synchronous-read memory, so each
// beat is a short read-modify-write sequence. The first letter of an insert
// also updates the root row; the last letter of a delete of a stored word
// walks the stored path; a clear writes each node in use in turn.
// After reset the block clears the root row before it accepts its first
// beat. One result waits in an output register, so a stalled receiver
// holds at most one finished result; the block then takes the next beat but
// does not finish it until that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_trie_counter_top_assert.svh"
module prefix_trie_counter_top #(
    parameter int NODES    = ptc_pkg::DEF_NODES,
    parameter int ALPHABET = ptc_pkg::DEF_ALPHABET,
    parameter int MAX_LEN  = ptc_pkg::DEF_MAX_LEN
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptc_in_if.sink     i_in,
    ptc_out_if.source  o_out
);
    import ptc_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int LW  = $clog2(ALPHABET);
    localparam int PLW = $clog2(MAX_LEN + 1);
    localparam int PIW = $clog2(MAX_LEN);
    localparam logic [NW-1:0]  ROOT      = NW'(1);
    localparam logic [NW-1:0]  LAST_NODE = NW'(NODES - 1);
    localparam logic [PLW-1:0] LEN_MAX   = PLW'(MAX_LEN);

    typedef struct packed {
        logic [ALPHABET-1:0][NW-1:0] link;
        logic [CNT_W-1:0]            pass;
        logic [CNT_W-1:0]            ends;
    } t_row;

    typedef struct packed {
        logic [NW-1:0] node;
        logic [LW-1:0] letter;
    } t_step;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_CLR   = 20'h00002,
        S_START = 20'h00004,
        S_ROOT  = 20'h00008,
        S_STEP  = 20'h00010,
        S_LINK  = 20'h00020,
        S_NEWN  = 20'h00040,
        S_INCP  = 20'h00080,
        S_LAST  = 20'h00100,
        S_CNT   = 20'h00200,
        S_DCHK  = 20'h00400,
        S_DROOT = 20'h00800,
        S_DPATH = 20'h01000,
        S_DPR   = 20'h02000,
        S_DP    = 20'h04000,
        S_DC    = 20'h08000,
        S_DCUT  = 20'h10000,
        S_DEND  = 20'h20000,
        S_DEND2 = 20'h40000,
        S_DONE  = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [NW-1:0]    r_next_free, n_next_free;
    logic [NW-1:0]    r_walk, n_walk;
    logic             r_inside, n_inside;
    t_func            r_op, n_op;
    logic             r_missing, n_missing;
    t_err             r_err, n_err;
    logic [PLW-1:0]   r_plen, n_plen;
    logic [LW-1:0]    r_letter, n_letter;
    logic             r_last, n_last;
    logic             r_newins, n_newins;
    logic [NW-1:0]    r_clr_idx, n_clr_idx;
    logic             r_clr_resp, n_clr_resp;
    logic [PIW-1:0]   r_i, n_i;
    logic [NW-1:0]    r_p, n_p;
    logic [LW-1:0]    r_pl, n_pl;
    logic [NW-1:0]    r_c, n_c;
    t_row             r_row, n_row;
    logic [CNT_W-1:0] r_res_count, n_res_count;
    logic             r_res_done, n_res_done;
    t_err             r_res_err, n_res_err;
    logic             r_ovalid, n_ovalid;
    logic [CNT_W-1:0] r_ocount, n_ocount;
    logic             r_odone, n_odone;
    t_err             r_oerr, n_oerr;

    logic             mem_rd_en;
    logic [NW-1:0]    mem_rd_addr;
    logic             mem_wr_en;
    logic [NW-1:0]    mem_wr_addr;
    t_row             mem_wr_row;
    logic [$bits(t_row)-1:0] mem_rd_data;
    t_row             rd_row;
    logic [NW-1:0]    nxt;
    logic             path_wr_en;
    logic [PIW-1:0]   path_wr_addr;
    t_step            path_wr_step;
    logic [$bits(t_step)-1:0] path_rd_data;
    t_step            path_step;
    logic [8:0]       letter_ext;
    logic [LW-1:0]    letter_clamp;

    assign rd_row    = t_row'(mem_rd_data);
    assign path_step = t_step'(path_rd_data);
    assign nxt       = rd_row.link[r_letter];
    assign letter_ext   = {4'b0, i_in.letter};
    assign letter_clamp = (letter_ext >= 9'(ALPHABET)) ? LW'(ALPHABET - 1)
                                                        : LW'(letter_ext);

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.count    = r_ocount;
    assign o_out.done_res = r_odone;
    assign o_out.error    = r_oerr;

    ptc_node_mem #(
        .DEPTH (NODES),
        .AW    (NW),
        .DW    ($bits(t_row))
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_row)
    );

    ptc_path_mem #(
        .DEPTH (MAX_LEN),
        .AW    (PIW),
        .DW    ($bits(t_step))
    ) u_path_mem (
        .i_clk     (i_clk),
        .i_rd_addr (r_i),
        .o_rd_data (path_rd_data),
        .i_wr_en   (path_wr_en),
        .i_wr_addr (path_wr_addr),
        .i_wr_data (path_wr_step)
    );

    always_comb begin
        n_state     = r_state;
        n_next_free = r_next_free;
        n_walk      = r_walk;
        n_inside    = r_inside;
        n_op        = r_op;
        n_missing   = r_missing;
        n_err       = r_err;
        n_plen      = r_plen;
        n_letter    = r_letter;
        n_last      = r_last;
        n_newins    = r_newins;
        n_clr_idx   = r_clr_idx;
        n_clr_resp  = r_clr_resp;
        n_i         = r_i;
        n_p         = r_p;
        n_pl        = r_pl;
        n_c         = r_c;
        n_row       = r_row;
        n_res_count = r_res_count;
        n_res_done  = r_res_done;
        n_res_err   = r_res_err;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_ocount    = r_ocount;
        n_odone     = r_odone;
        n_oerr      = r_oerr;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_walk;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_walk;
        mem_wr_row   = rd_row;
        path_wr_en   = 1'b0;
        path_wr_addr = r_plen[PIW-1:0];
        path_wr_step = '{node: r_walk, letter: r_letter};

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_count = '0;
                    n_res_done  = 1'b0;
                    n_res_err   = ER_NONE;
                    n_letter    = letter_clamp;
                    n_last      = i_in.last;
                    case (t_func'(i_in.func))
                        FN_CLEAR: begin
                            n_clr_idx  = ROOT;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLR;
                        end
                        FN_INSERT, FN_DELETE, FN_SEARCH, FN_PREFIX: begin
                            n_newins = 1'b0;
                            if (!r_inside) begin
                                n_inside  = 1'b1;
                                n_op      = t_func'(i_in.func);
                                n_missing = 1'b0;
                                n_err     = ER_NONE;
                                n_plen    = '0;
                                n_walk    = ROOT;
                                n_newins  = (t_func'(i_in.func) == FN_INSERT);
                            end
                            n_state = S_START;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_idx;
                mem_wr_row  = '0;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx >= r_next_free) begin
                    n_next_free = ROOT;
                    n_walk      = ROOT;
                    n_inside    = 1'b0;
                    n_missing   = 1'b0;
                    n_err       = ER_NONE;
                    n_plen      = '0;
                    n_res_done  = 1'b1;
                    n_state     = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_START: begin
                if (r_newins) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ROOT;
                    n_state     = S_ROOT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_ROOT: begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = ROOT;
                mem_wr_row.pass  = sat_inc(rd_row.pass);
                n_state          = S_STEP;
            end
            S_STEP: begin
                if (!r_missing && r_err == ER_NONE) begin
                    mem_rd_en = 1'b1;
                    n_state   = S_LINK;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LINK: begin
                n_state = S_LAST;
                case (r_op)
                    FN_INSERT: begin
                        if (nxt == '0) begin
                            if (r_next_free >= LAST_NODE) begin
                                n_err = ER_FULL;
                            end else begin
                                n_next_free = r_next_free + 1'b1;
                                mem_wr_en   = 1'b1;
                                mem_wr_row.link[r_letter] = r_next_free + 1'b1;
                                n_walk      = r_next_free + 1'b1;
                                n_state     = S_NEWN;
                            end
                        end else begin
                            n_walk      = nxt;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = nxt;
                            n_state     = S_INCP;
                        end
                    end
                    FN_DELETE: begin
                        if (nxt == '0) begin
                            n_missing = 1'b1;
                        end else if (r_plen >= LEN_MAX) begin
                            n_err = ER_LONG;
                        end else begin
                            path_wr_en = 1'b1;
                            n_plen     = r_plen + 1'b1;
                            n_walk     = nxt;
                        end
                    end
                    default: begin
                        if (nxt == '0) begin
                            n_missing = 1'b1;
                        end else begin
                            n_walk = nxt;
                        end
                    end
                endcase
            end
            S_NEWN: begin
                mem_wr_en       = 1'b1;
                mem_wr_row      = '0;
                mem_wr_row.pass = CNT_W'(1);
                mem_wr_row.ends = CNT_W'(r_last);
                n_state         = S_LAST;
            end
            S_INCP: begin
                mem_wr_en       = 1'b1;
                mem_wr_row.pass = sat_inc(rd_row.pass);
                if (r_last) begin
                    mem_wr_row.ends = sat_inc(rd_row.ends);
                end
                n_state = S_LAST;
            end
            S_LAST: begin
                n_res_done = r_last;
                n_res_err  = r_err;
                n_state    = S_DONE;
                if (r_last) begin
                    n_inside = 1'b0;
                    case (r_op)
                        FN_SEARCH, FN_PREFIX: begin
                            if (!r_missing) begin
                                mem_rd_en = 1'b1;
                                n_state   = S_CNT;
                            end
                        end
                        FN_DELETE: begin
                            if (!r_missing && r_err == ER_NONE) begin
                                mem_rd_en = 1'b1;
                                n_state   = S_DCHK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CNT: begin
                n_res_count = (r_op == FN_SEARCH) ? rd_row.ends : rd_row.pass;
                n_state     = S_DONE;
            end
            S_DCHK: begin
                if (rd_row.ends == '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ROOT;
                    n_state     = S_DROOT;
                end
            end
            S_DROOT: begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = ROOT;
                mem_wr_row.pass = sat_dec(rd_row.pass);
                n_i             = '0;
                n_state         = S_DPATH;
            end
            S_DPATH: begin
                n_state = S_DPR;
            end
            S_DPR: begin
                n_p         = path_step.node;
                n_pl        = path_step.letter;
                mem_rd_en   = 1'b1;
                mem_rd_addr = path_step.node;
                n_state     = S_DP;
            end
            S_DP: begin
                n_row       = rd_row;
                n_c         = rd_row.link[r_pl];
                mem_rd_en   = 1'b1;
                mem_rd_addr = rd_row.link[r_pl];
                n_state     = S_DC;
            end
            S_DC: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_c;
                if (rd_row.pass <= CNT_W'(1)) begin
                    mem_wr_row.pass = '0;
                    n_state         = S_DCUT;
                end else begin
                    mem_wr_row.pass = rd_row.pass - 1'b1;
                    if ((PLW'(r_i) + 1'b1) < r_plen) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_DPATH;
                    end else begin
                        n_state = S_DEND;
                    end
                end
            end
            S_DCUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_p;
                mem_wr_row  = r_row;
                mem_wr_row.link[r_pl] = '0;
                n_state     = S_DONE;
            end
            S_DEND: begin
                mem_rd_en = 1'b1;
                n_state   = S_DEND2;
            end
            S_DEND2: begin
                mem_wr_en       = 1'b1;
                mem_wr_row.ends = rd_row.ends - 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ocount = r_res_count;
                    n_odone  = r_res_done;
                    n_oerr   = r_res_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_next_free <= ROOT;
            r_walk      <= ROOT;
            r_inside    <= 1'b0;
            r_op        <= FN_INSERT;
            r_missing   <= 1'b0;
            r_err       <= ER_NONE;
            r_plen      <= '0;
            r_newins    <= 1'b0;
            r_clr_idx   <= ROOT;
            r_clr_resp  <= 1'b0;
            r_i         <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_walk      <= n_walk;
            r_inside    <= n_inside;
            r_op        <= n_op;
            r_missing   <= n_missing;
            r_err       <= n_err;
            r_plen      <= n_plen;
            r_newins    <= n_newins;
            r_clr_idx   <= n_clr_idx;
            r_clr_resp  <= n_clr_resp;
            r_i         <= n_i;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_letter    <= n_letter;
        r_last      <= n_last;
        r_p         <= n_p;
        r_pl        <= n_pl;
        r_c         <= n_c;
        r_row       <= n_row;
        r_res_count <= n_res_count;
        r_res_done  <= n_res_done;
        r_res_err   <= n_res_err;
        r_ocount    <= n_ocount;
        r_odone     <= n_odone;
        r_oerr      <= n_oerr;
    end

    `PTC_ASSERT(a_free_range, i_clk, i_rst_n,
                (r_next_free >= ROOT) && (r_next_free <= LAST_NODE))
    `PTC_ASSERT(a_plen_range, i_clk, i_rst_n, r_plen <= LEN_MAX)
    `PTC_ASSERT(a_no_rw_clash, i_clk, i_rst_n,
                !(mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr)))
    `PTC_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
                     (r_state == S_DONE) && r_ovalid && !o_out.ready,
                     r_state == S_DONE)
endmodule
`default_nettype wire

@@ tb/tb_prefix_trie_counter_top.sv @@
// -----------------------------------------------------------------------------
// Prefix trie counter testbench
// Drives letter beats with random gaps, predicts every result beat from a
// private copy of the trie and compares each beat field by field.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_prefix_trie_counter_top;
    import ptc_pkg::*;

    localparam int NODES    = DEF_NODES;
    localparam int ALPHABET = DEF_ALPHABET;
    localparam int MAX_LEN  = DEF_MAX_LEN;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             done_res;
        logic [ERR_W-1:0] error;
    } t_result;

    class trie_scoreboard;
        logic [11:0]      link [NODES*ALPHABET];
        logic [CNT_W-1:0] ends [NODES];
        logic [CNT_W-1:0] pass [NODES];
        int               top_node;
        int               cur;
        int               trail_node [MAX_LEN];
        int               trail_ltr [MAX_LEN];
        int               trail_len;
        bit               missing;
        bit               busy;
        logic [2:0]       op;
        logic [ERR_W-1:0] werr;
        t_result          pending [$];
        int               errors;
        int               checked;

        function new();
            foreach (link[i]) link[i] = '0;
            foreach (ends[i]) begin
                ends[i] = '0;
                pass[i] = '0;
            end
            top_node = 1;
            cur = 1;
            trail_len = 0;
            missing = 0;
            busy = 0;
            op = FN_INSERT;
            werr = ER_NONE;
            errors = 0;
            checked = 0;
        endfunction

        function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void remove_word();
            int a;
            int c;
            if (missing || werr != ER_NONE || ends[cur] == 0) return;
            if (pass[1] > 0) pass[1]--;
            for (int i = 0; i < trail_len; i++) begin
                a = trail_node[i] * ALPHABET + trail_ltr[i];
                c = link[a];
                if (pass[c] <= 1) begin
                    pass[c] = '0;
                    link[a] = '0;
                    return;
                end
                pass[c]--;
            end
            ends[cur]--;
        endfunction

        function void note_beat(logic [2:0] fn, logic [4:0] ltr_in, logic lst);
            t_result r;
            int ltr;
            int a;
            int nx;
            r = '0;
            if (fn > FN_CLEAR) begin
                pending.push_back(r);
                return;
            end
            if (fn == FN_CLEAR) begin
                for (int i = 1; i <= top_node && i < NODES; i++) begin
                    for (int k = 0; k < ALPHABET; k++) link[i*ALPHABET+k] = '0;
                    ends[i] = '0;
                    pass[i] = '0;
                end
                top_node = 1;
                cur = 1;
                busy = 0;
                missing = 0;
                werr = ER_NONE;
                trail_len = 0;
                r.done_res = 1'b1;
                pending.push_back(r);
                return;
            end
            ltr = (ltr_in >= ALPHABET) ? ALPHABET - 1 : ltr_in;
            if (!busy) begin
                busy = 1;
                op = fn;
                missing = 0;
                werr = ER_NONE;
                trail_len = 0;
                cur = 1;
                if (op == FN_INSERT) pass[1] = bump(pass[1]);
            end
            if (!missing && werr == ER_NONE) begin
                a = cur * ALPHABET + ltr;
                nx = link[a];
                if (op == FN_INSERT) begin
                    if (nx == 0) begin
                        if (top_node >= NODES - 1) werr = ER_FULL;
                        else begin
                            top_node++;
                            link[a] = 12'(top_node);
                            nx = top_node;
                        end
                    end
                    if (werr == ER_NONE) begin
                        cur = nx;
                        pass[nx] = bump(pass[nx]);
                    end
                end else if (nx == 0) begin
                    missing = 1;
                end else if (op == FN_DELETE) begin
                    if (trail_len >= MAX_LEN) werr = ER_LONG;
                    else begin
                        trail_node[trail_len] = cur;
                        trail_ltr[trail_len] = ltr;
                        trail_len++;
                        cur = nx;
                    end
                end else begin
                    cur = nx;
                end
            end
            if (lst) begin
                if (op == FN_INSERT) begin
                    if (werr == ER_NONE) ends[cur] = bump(ends[cur]);
                end else if (op == FN_DELETE) begin
                    remove_word();
                end else if (!missing) begin
                    r.count = (op == FN_SEARCH) ? ends[cur] : pass[cur];
                end
                r.done_res = 1'b1;
                busy = 0;
            end
            r.error = werr;
            pending.push_back(r);
        endfunction

        function void check_beat(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.count !== exp_r.count)
                $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
            if (got.done_res !== exp_r.done_res)
                $display("%0t: done_res expected %0b actual %0b", $time, exp_r.done_res,
                         got.done_res);
            if (got.error !== exp_r.error)
                $display("%0t: error expected %0d actual %0d", $time, exp_r.error, got.error);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    prefix_trie_counter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    trie_scoreboard sb;
    int cycles;
    int beats_sent;
    int burst_left;
    int stall_mode;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("prefix_trie_counter_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_beat({out_ch.count, out_ch.done_res, out_ch.error});
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(3) != 0);
            2: out_ch.ready <= ($urandom_range(3) == 0);
            default: out_ch.ready <= (cycles % 7) < 4;
        endcase
        if ($urandom_range(199) == 0) stall_mode <= $urandom_range(3);
    end

    task automatic send_beat(logic [2:0] fn, logic [4:0] ltr, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= fn;
        in_ch.letter <= ltr;
        in_ch.last   <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_beat(fn, ltr, lst);
        beats_sent++;
        burst_left--;
    endtask

    task automatic send_word(logic [2:0] fn, int len, int span);
        logic [2:0] f;
        for (int i = 0; i < len; i++) begin
            f = (i > 0 && $urandom_range(9) == 0) ? 3'($urandom_range(3)) : fn;
            send_beat(f, 5'($urandom_range(span - 1)), i == len - 1);
        end
    endtask

    task automatic send_fixed(logic [2:0] fn, int len, logic [4:0] ltr);
        for (int i = 0; i < len; i++) send_beat(fn, ltr, i == len - 1);
    endtask

    int pick;
    int len;
    int span;

    initial begin
        sb = new();
        cycles = 0;
        beats_sent = 0;
        burst_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.letter = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_fixed(FN_SEARCH, 2, 5'd0);
        send_fixed(FN_INSERT, 3, 5'd0);
        send_fixed(FN_INSERT, 3, 5'd0);
        send_fixed(FN_SEARCH, 3, 5'd0);
        send_fixed(FN_PREFIX, 2, 5'd0);
        send_beat(FN_INSERT, 5'd31, 1'b1);
        send_beat(FN_SEARCH, 5'd25, 1'b1);
        send_beat(3'd5, 5'd3, 1'b1);
        send_beat(3'd7, 5'd31, 1'b0);
        send_fixed(FN_DELETE, 3, 5'd0);
        send_fixed(FN_SEARCH, 3, 5'd0);
        send_beat(FN_INSERT, 5'd1, 1'b0);
        send_beat(FN_CLEAR, 5'd0, 1'b0);
        send_fixed(FN_DELETE, 2, 5'd4);
        send_fixed(FN_INSERT, 66, 5'd2);
        send_fixed(FN_DELETE, 66, 5'd2);

        while (beats_sent < 800) begin
            pick = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? 32 : $urandom_range(2, 4);
            len = ($urandom_range(19) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 5);
            if (pick < 40) send_word(FN_INSERT, len, span);
            else if (pick < 55) send_word(FN_DELETE, len, span);
            else if (pick < 75) send_word(FN_SEARCH, len, span);
            else if (pick < 93) send_word(FN_PREFIX, len, span);
            else if (pick < 96) send_beat(FN_CLEAR, 5'($urandom_range(31)), 1'($urandom));
            else send_beat(3'($urandom_range(5, 7)), 5'($urandom_range(31)), 1'($urandom));
        end
        for (int n = 0; n < 2; n++) send_word(FN_INSERT, 70, 26);
        send_word(FN_SEARCH, 3, 26);
        send_beat(FN_CLEAR, 5'd0, 1'b1);
        send_word(FN_INSERT, 2, 26);
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        $display("Sent %0d letter beats of every operation, checked %0d result beats.",
                 beats_sent, sb.checked);
        $display("Covered long inserts and deletes, clears and unused codes.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("prefix_trie_counter_top: match");
        else
            $display("prefix_trie_counter_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
